FILE: rtl/core/mcbq_pkg.sv
// Shared constants and types for the multichannel biquad filter core.
package mcbq_pkg;

	localparam int CHANNELS  = 8;
	localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CH_W      = 3;
	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 32;
	localparam int FRAC_BITS = 28;
	localparam int NUM_COEF  = 5;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = COEF_W + SAMPLE_W;
	localparam int ACC_W     = PROD_W + 4;
	localparam int RES_W     = ACC_W - FRAC_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_B0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_B1 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_B2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_A1 = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_A2 = CFG_IDX_W'(4);

	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) <<< FRAC_BITS;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t y2;
		sample_t y1;
		sample_t x2;
		sample_t x1;
	} hist_t;

	localparam int HIST_W = $bits(hist_t);

endpackage

FILE: rtl/core/multichannel_biquad_filter_core.sv
// Top level of the multichannel direct form I biquad filter with per-channel history RAM.
//
// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    s_tdata: sample_in; s_tuser: channel
// m_*       out        m_tvalid / m_tready    m_tdata: sample_out; m_tuser: channel_out, clipped
// cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data (coefficients b0 b1 b2 a1 a2)
//
// An accepted sample passes stages one, two and three before it reaches the output register.
// Samples of different channels are taken one per cycle while the output is not held; a
// sample whose channel is still in the pipeline waits until that channel's history is
// written back.
// Reset clears the coefficients to their defaults and marks every history entry as zero.
// The whole pipeline holds while the output register is full and not taken.
module multichannel_biquad_filter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mcbq_pkg::SAMPLE_W-1:0]   s_tdata,   // [23:0] sample_in
	input  logic [mcbq_pkg::CH_W-1:0]       s_tuser,   // [2:0] channel
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mcbq_pkg::SAMPLE_W-1:0]   m_tdata,   // [23:0] sample_out
	output logic [mcbq_pkg::CH_W:0]         m_tuser,   // [2:0] channel_out, [3] clipped
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mcbq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mcbq_pkg::COEF_W-1:0]     cfg_data
);

	logic signed [mcbq_pkg::COEF_W-1:0] coef_q [mcbq_pkg::NUM_COEF];
	logic [mcbq_pkg::CHANNELS-1:0]      vld_q;

	logic                              adv;
	logic                              hazard;
	logic                              accept;
	logic                              present;
	mcbq_pkg::sample_t                 x_in;

	logic                              valid_s1;
	logic [mcbq_pkg::CH_W-1:0]         ch_s1;
	mcbq_pkg::sample_t                 x_s1;

	logic [mcbq_pkg::HIST_W-1:0]       rdata;
	mcbq_pkg::hist_t                   hist_c;

	logic                              valid_s2;
	logic [mcbq_pkg::CH_W-1:0]         ch_s2;
	mcbq_pkg::sample_t                 x_s2;
	mcbq_pkg::sample_t                 x1_s2;
	mcbq_pkg::sample_t                 y1_s2;
	logic signed [mcbq_pkg::PROD_W-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2;

	logic                              valid_s3;
	logic [mcbq_pkg::CH_W-1:0]         ch_s3;
	mcbq_pkg::sample_t                 x_s3;
	mcbq_pkg::sample_t                 x1_s3;
	mcbq_pkg::sample_t                 y1_s3;
	logic signed [mcbq_pkg::ACC_W-1:0] ff_s3;
	logic signed [mcbq_pkg::ACC_W-1:0] fb_s3;

	logic signed [mcbq_pkg::ACC_W-1:0] acc_c;
	logic signed [mcbq_pkg::RES_W-1:0] res_c;
	logic                              over_c;
	logic                              under_c;
	mcbq_pkg::sample_t                 sat_c;
	mcbq_pkg::hist_t                   wr_c;
	logic                              wr_en;

	mcbq_pkg::sample_t                 out_sample_q;
	logic [mcbq_pkg::CH_W-1:0]         out_ch_q;
	logic                              out_clip_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= mcbq_pkg::COEF_ONE;
			for (int i = 1; i < mcbq_pkg::NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mcbq_pkg::REG_B0: coef_q[0] <= cfg_data;
				mcbq_pkg::REG_B1: coef_q[1] <= cfg_data;
				mcbq_pkg::REG_B2: coef_q[2] <= cfg_data;
				mcbq_pkg::REG_A1: coef_q[3] <= cfg_data;
				mcbq_pkg::REG_A2: coef_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline advances whenever the output register can take a new result.
	assign adv     = !m_tvalid || m_tready;
	assign hazard  = (valid_s1 && (ch_s1 == s_tuser)) || (valid_s2 && (ch_s2 == s_tuser)) ||
		(valid_s3 && (ch_s3 == s_tuser));
	assign s_tready = adv && !hazard;
	assign accept  = s_tvalid && s_tready;
	assign present = 32'(s_tuser) < mcbq_pkg::CHANNELS;
	assign x_in    = s_tdata[mcbq_pkg::SAMPLE_W-1:0];

	mcbq_ram #(
		.WIDTH(mcbq_pkg::HIST_W),
		.DEPTH(mcbq_pkg::CHANNELS)
	) u_hist_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (mcbq_pkg::ADDR_W'(ch_s3)),
		.wdata (wr_c),
		.re    (accept),
		.raddr (mcbq_pkg::ADDR_W'(s_tuser)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept && present;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			m_tvalid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1 <= s_tuser;
			x_s1  <= x_in;
		end
	end

	// History entries never written since reset read as zero.
	always_comb begin
		hist_c = rdata;
		if (!vld_q[mcbq_pkg::ADDR_W'(ch_s1)]) begin
			hist_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s2 <= ch_s1;
			x_s2  <= x_s1;
			x1_s2 <= hist_c.x1;
			y1_s2 <= hist_c.y1;
			p0_s2 <= coef_q[0] * x_s1;
			p1_s2 <= coef_q[1] * hist_c.x1;
			p2_s2 <= coef_q[2] * hist_c.x2;
			p3_s2 <= coef_q[3] * hist_c.y1;
			p4_s2 <= coef_q[4] * hist_c.y2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s3 <= ch_s2;
			x_s3  <= x_s2;
			x1_s3 <= x1_s2;
			y1_s3 <= y1_s2;
			ff_s3 <= mcbq_pkg::ACC_W'(p0_s2) + mcbq_pkg::ACC_W'(p1_s2) +
				mcbq_pkg::ACC_W'(p2_s2) + mcbq_pkg::ROUND_HALF;
			fb_s3 <= mcbq_pkg::ACC_W'(p3_s2) + mcbq_pkg::ACC_W'(p4_s2);
		end
	end

	assign acc_c   = ff_s3 - fb_s3;
	assign res_c   = acc_c[mcbq_pkg::ACC_W-1:mcbq_pkg::FRAC_BITS];
	assign over_c  = !res_c[mcbq_pkg::RES_W-1] &&
		(|res_c[mcbq_pkg::RES_W-2:mcbq_pkg::SAMPLE_W-1]);
	assign under_c = res_c[mcbq_pkg::RES_W-1] &&
		!(&res_c[mcbq_pkg::RES_W-2:mcbq_pkg::SAMPLE_W-1]);

	always_comb begin
		sat_c = res_c[mcbq_pkg::SAMPLE_W-1:0];
		if (over_c) begin
			sat_c = {1'b0, {(mcbq_pkg::SAMPLE_W-1){1'b1}}};
		end else if (under_c) begin
			sat_c = {1'b1, {(mcbq_pkg::SAMPLE_W-1){1'b0}}};
		end
	end

	assign wr_c.y2 = y1_s3;
	assign wr_c.y1 = sat_c;
	assign wr_c.x2 = x1_s3;
	assign wr_c.x1 = x_s3;
	assign wr_en   = adv && valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[mcbq_pkg::ADDR_W'(ch_s3)] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			out_sample_q <= sat_c;
			out_ch_q     <= ch_s3;
			out_clip_q   <= over_c || under_c;
		end
	end

	assign m_tdata = out_sample_q;
	assign m_tuser = {out_clip_q, out_ch_q};

	a_no_overlap_12: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 |-> ch_s1 != ch_s2)
		else $error("Two in-flight samples of one channel in stages one and two.");

	a_no_overlap_13: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s3 |-> ch_s1 != ch_s3)
		else $error("Two in-flight samples of one channel in stages one and three.");

	a_no_overlap_23: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && valid_s3 |-> ch_s2 != ch_s3)
		else $error("Two in-flight samples of one channel in stages two and three.");

	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_clip_q |->
		(out_sample_q == {1'b0, {(mcbq_pkg::SAMPLE_W-1){1'b1}}}) ||
		(out_sample_q == {1'b1, {(mcbq_pkg::SAMPLE_W-1){1'b0}}}))
		else $error("Clipped result is not at a saturation limit.");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept && present |=> valid_s1)
		else $error("An accepted sample did not enter the pipeline.");

endmodule

FILE: rtl/core/mcbq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module mcbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: bench/multichannel_biquad_filter_core_tb.sv
// Self-checking testbench for the multichannel direct form I biquad filter core.
module multichannel_biquad_filter_core_tb;

	localparam int CLK_PERIOD     = 4;
	localparam int PIPE_LAT       = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RAND_PHASES    = 8;
	localparam int PHASE_ITEMS    = 178;

	localparam logic [mcbq_pkg::COEF_W-1:0] COEF_MAX = {1'b0, {(mcbq_pkg::COEF_W-1){1'b1}}};
	localparam logic [mcbq_pkg::COEF_W-1:0] COEF_MIN = {1'b1, {(mcbq_pkg::COEF_W-1){1'b0}}};
	localparam mcbq_pkg::sample_t SMP_MAX = {1'b0, {(mcbq_pkg::SAMPLE_W-1){1'b1}}};
	localparam mcbq_pkg::sample_t SMP_MIN = {1'b1, {(mcbq_pkg::SAMPLE_W-1){1'b0}}};
	localparam longint SAT_HI = (longint'(1) <<< (mcbq_pkg::SAMPLE_W-1)) - 1;
	localparam longint SAT_LO = -(longint'(1) <<< (mcbq_pkg::SAMPLE_W-1));

	typedef struct packed {
		logic [mcbq_pkg::CH_W-1:0] ch;
		mcbq_pkg::sample_t         smp;
		logic                      clip;
	} filt_result_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [mcbq_pkg::SAMPLE_W-1:0]  s_tdata   = '0;
	logic [mcbq_pkg::CH_W-1:0]      s_tuser   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [mcbq_pkg::SAMPLE_W-1:0]  m_tdata;
	logic [mcbq_pkg::CH_W:0]        m_tuser;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [mcbq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mcbq_pkg::COEF_W-1:0]    cfg_data  = '0;

	logic signed [mcbq_pkg::COEF_W-1:0] coef_reg [mcbq_pkg::NUM_COEF];
	mcbq_pkg::sample_t hist_x1 [mcbq_pkg::CHANNELS] = '{default: '0};
	mcbq_pkg::sample_t hist_x2 [mcbq_pkg::CHANNELS] = '{default: '0};
	mcbq_pkg::sample_t hist_y1 [mcbq_pkg::CHANNELS] = '{default: '0};
	mcbq_pkg::sample_t hist_y2 [mcbq_pkg::CHANNELS] = '{default: '0};

	filt_result_t filtered_q [$];
	int err_cnt     = 0;
	int idle_cycles = 0;
	int stall_pct   = 0;
	int gap_pct     = 0;
	int rdy_hold    = 0;

	multichannel_biquad_filter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	function automatic filt_result_t biquad_step(input logic [mcbq_pkg::CH_W-1:0] ch,
			input mcbq_pkg::sample_t x);
		longint acc;
		longint rnd;
		filt_result_t res;
		acc = longint'(coef_reg[mcbq_pkg::REG_B0]) * longint'(x)
			+ longint'(coef_reg[mcbq_pkg::REG_B1]) * longint'(hist_x1[ch])
			+ longint'(coef_reg[mcbq_pkg::REG_B2]) * longint'(hist_x2[ch])
			- longint'(coef_reg[mcbq_pkg::REG_A1]) * longint'(hist_y1[ch])
			- longint'(coef_reg[mcbq_pkg::REG_A2]) * longint'(hist_y2[ch]);
		rnd = (acc + (longint'(1) <<< (mcbq_pkg::FRAC_BITS-1))) >>> mcbq_pkg::FRAC_BITS;
		res.ch = ch;
		res.clip = 1'b0;
		if (rnd > SAT_HI) begin
			rnd = SAT_HI;
			res.clip = 1'b1;
		end else if (rnd < SAT_LO) begin
			rnd = SAT_LO;
			res.clip = 1'b1;
		end
		res.smp = mcbq_pkg::sample_t'(rnd);
		hist_x2[ch] = hist_x1[ch];
		hist_x1[ch] = x;
		hist_y2[ch] = hist_y1[ch];
		hist_y1[ch] = res.smp;
		return res;
	endfunction

	function automatic mcbq_pkg::sample_t rand_sample();
		case ($urandom_range(0, 9))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2, 3: return mcbq_pkg::sample_t'(int'($urandom_range(0, 1023)) - 512);
			default: return mcbq_pkg::sample_t'($urandom());
		endcase
	endfunction

	function automatic logic [mcbq_pkg::COEF_W-1:0] rand_coef(input bit wide);
		int v;
		v = int'($urandom_range(0, 1 << 28)) - (1 << 27);
		if (wide) begin
			case ($urandom_range(0, 7))
				0: return COEF_MAX;
				1: return COEF_MIN;
				2: return '0;
				3, 4: return $urandom();
				default: return mcbq_pkg::COEF_W'(v);
			endcase
		end
		return mcbq_pkg::COEF_W'(v);
	endfunction

	task automatic send_sample(input logic [mcbq_pkg::CH_W-1:0] ch, input mcbq_pkg::sample_t x);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= x;
		s_tuser  <= ch;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		filtered_q.push_back(biquad_step(ch, x));
	endtask

	task automatic sender_pause(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
	endtask

	task automatic hold_until_empty();
		sender_pause(1);
		while (filtered_q.size() != 0) @(posedge clk);
	endtask

	task automatic wait_drain();
		hold_until_empty();
		repeat (PIPE_LAT * 4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [mcbq_pkg::CFG_IDX_W-1:0] idx,
			input logic [mcbq_pkg::COEF_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx < mcbq_pkg::NUM_COEF)
			coef_reg[idx] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_coefs(input logic [mcbq_pkg::COEF_W-1:0] b0,
			input logic [mcbq_pkg::COEF_W-1:0] b1, input logic [mcbq_pkg::COEF_W-1:0] b2,
			input logic [mcbq_pkg::COEF_W-1:0] a1, input logic [mcbq_pkg::COEF_W-1:0] a2);
		cfg_write(mcbq_pkg::REG_B0, b0);
		cfg_write(mcbq_pkg::REG_B1, b1);
		cfg_write(mcbq_pkg::REG_B2, b2);
		cfg_write(mcbq_pkg::REG_A1, a1);
		cfg_write(mcbq_pkg::REG_A2, a2);
	endtask

	task automatic test_passthrough();
		mcbq_pkg::sample_t pattern [mcbq_pkg::CHANNELS];
		pattern = '{SMP_MAX, SMP_MIN, '0, '1, mcbq_pkg::sample_t'(1),
			mcbq_pkg::sample_t'(24'h555555), mcbq_pkg::sample_t'(24'hAAAAAA),
			mcbq_pkg::sample_t'(12345)};
		for (int i = 0; i < mcbq_pkg::CHANNELS; i++)
			send_sample(mcbq_pkg::CH_W'(i), pattern[i]);
		wait_drain();
	endtask

	task automatic test_config_regs();
		set_coefs(rand_coef(1'b0), rand_coef(1'b0), rand_coef(1'b0), rand_coef(1'b0),
			rand_coef(1'b0));
		for (int i = mcbq_pkg::NUM_COEF; i < (1 << mcbq_pkg::CFG_IDX_W); i++)
			cfg_write(mcbq_pkg::CFG_IDX_W'(i), $urandom());
		send_sample(mcbq_pkg::CH_W'(5), rand_sample());
		send_sample(mcbq_pkg::CH_W'(5), rand_sample());
		send_sample(mcbq_pkg::CH_W'(6), rand_sample());
		wait_drain();
	endtask

	task automatic test_clipping();
		set_coefs(COEF_MAX, '0, '0, COEF_MIN, '0);
		send_sample(mcbq_pkg::CH_W'(0), SMP_MAX);
		send_sample(mcbq_pkg::CH_W'(0), '0);
		send_sample(mcbq_pkg::CH_W'(1), SMP_MIN);
		send_sample(mcbq_pkg::CH_W'(2), mcbq_pkg::sample_t'(1));
		wait_drain();
	endtask

	task automatic test_coef_extremes();
		set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
		send_sample(mcbq_pkg::CH_W'(3), SMP_MAX);
		send_sample(mcbq_pkg::CH_W'(3), SMP_MIN);
		send_sample(mcbq_pkg::CH_W'(3), SMP_MAX);
		send_sample(mcbq_pkg::CH_W'(3), SMP_MIN);
		wait_drain();
		set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		send_sample(mcbq_pkg::CH_W'(3), SMP_MAX);
		send_sample(mcbq_pkg::CH_W'(7), SMP_MIN);
		wait_drain();
	endtask

	task automatic test_rounding();
		set_coefs(mcbq_pkg::COEF_ONE >>> 1, '0, '0, '0, '0);
		send_sample(mcbq_pkg::CH_W'(4), mcbq_pkg::sample_t'(1));
		send_sample(mcbq_pkg::CH_W'(4), mcbq_pkg::sample_t'(-1));
		send_sample(mcbq_pkg::CH_W'(4), mcbq_pkg::sample_t'(3));
		send_sample(mcbq_pkg::CH_W'(4), mcbq_pkg::sample_t'(-3));
		wait_drain();
	endtask

	task automatic test_random_phases();
		int pcts [3];
		int ch_mode;
		bit wide;
		logic [mcbq_pkg::CH_W-1:0] ch_a;
		logic [mcbq_pkg::CH_W-1:0] ch_b;
		logic [mcbq_pkg::CH_W-1:0] ch;
		pcts = '{0, 20, 50};
		for (int p = 0; p < RAND_PHASES; p++) begin
			wide = (p % 2 == 1);
			set_coefs(rand_coef(wide), rand_coef(wide), rand_coef(wide), rand_coef(wide),
				rand_coef(wide));
			if (p == RAND_PHASES - 1) begin
				stall_pct = 0;
				gap_pct = 0;
			end else begin
				stall_pct = pcts[$urandom_range(0, 2)];
				gap_pct = pcts[$urandom_range(0, 2)];
			end
			ch_mode = $urandom_range(0, 2);
			ch_a = mcbq_pkg::CH_W'($urandom_range(0, mcbq_pkg::CHANNELS-1));
			ch_b = mcbq_pkg::CH_W'($urandom_range(0, mcbq_pkg::CHANNELS-1));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2 && p != RAND_PHASES - 1)
					hold_until_empty();
				if ($urandom_range(0, 99) < gap_pct)
					sender_pause($urandom_range(1, 5));
				case (ch_mode)
					0: ch = mcbq_pkg::CH_W'($urandom_range(0, mcbq_pkg::CHANNELS-1));
					1: ch = $urandom_range(0, 1) ? ch_a : ch_b;
					default: ch = ch_a;
				endcase
				send_sample(ch, rand_sample());
			end
			wait_drain();
		end
	endtask

	always @(negedge clk) begin
		if (rdy_hold > 0) begin
			rdy_hold <= rdy_hold - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			rdy_hold <= $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		filt_result_t want;
		mcbq_pkg::sample_t got_smp;
		if (m_tvalid && m_tready) begin
			got_smp = m_tdata[mcbq_pkg::SAMPLE_W-1:0];
			if (filtered_q.size() == 0) begin
				$display("%0t: unexpected output: expected none, got channel %0d sample %0d",
					$time, m_tuser[mcbq_pkg::CH_W-1:0], got_smp);
				err_cnt++;
			end else begin
				want = filtered_q.pop_front();
				if (m_tuser[mcbq_pkg::CH_W-1:0] !== want.ch) begin
					$display("%0t: channel_out mismatch: expected %0d, got %0d",
						$time, want.ch, m_tuser[mcbq_pkg::CH_W-1:0]);
					err_cnt++;
				end
				if (got_smp !== want.smp) begin
					$display("%0t: sample_out mismatch on channel %0d: expected %0d, got %0d",
						$time, want.ch, want.smp, got_smp);
					err_cnt++;
				end
				if (m_tuser[mcbq_pkg::CH_W] !== want.clip) begin
					$display("%0t: clipped mismatch on channel %0d: expected %0b, got %0b",
						$time, want.ch, want.clip, m_tuser[mcbq_pkg::CH_W]);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired with %0d results outstanding", $time,
				filtered_q.size());
			$display("multichannel_biquad_filter_core_tb failed");
			$finish;
		end
	end

	initial begin
		coef_reg = '{default: '0};
		coef_reg[mcbq_pkg::REG_B0] = mcbq_pkg::COEF_ONE;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_passthrough();
		test_config_regs();
		test_clipping();
		test_coef_extremes();
		test_rounding();
		test_random_phases();
		if (err_cnt == 0)
			$display("multichannel_biquad_filter_core_tb passed");
		else
			$display("multichannel_biquad_filter_core_tb failed");
		$finish;
	end

endmodule
